[rtl/assert_macros.svh]
// Assertion helpers for the lbs block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> c holds in the same cycle
`define LBS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// a holds -> c holds in the next cycle
`define LBS_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

[rtl/lbs_pkg.sv]
`default_nettype none
package lbs_pkg;
	localparam int MAX_BONES  = 64;
	localparam int MAT_ELEMS  = 12;
	localparam int BONE_W     = 6;
	localparam int IDX_W      = 4;
	localparam int DATA_W     = 32;
	localparam int WGT_W      = 16;
	localparam int ACC_W      = 48;
	localparam int TBL_DEPTH  = MAX_BONES * MAT_ELEMS;
	localparam int TBL_AW     = $clog2(TBL_DEPTH);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		OP_MATRIX = 2'd0,
		OP_FLAG   = 2'd1,
		OP_BLEND  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// blend command handed from front to back
	typedef struct packed {
		logic [BONE_W-1:0]        bone;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic [WGT_W-1:0]         w;
		logic                     last;
		logic                     active;
	} cmd_t;

	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [BONE_W-1:0] bone,
			input logic [IDX_W-1:0] idx);
		tbl_addr = TBL_AW'(int'(bone) * MAT_ELEMS + int'(idx));
	endfunction
endpackage
`default_nettype wire

[rtl/lbs_ram.sv]
`default_nettype none
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/lbs_fifo.sv]
`default_nettype none
module lbs_fifo import lbs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);
	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/lbs_front.sv]
`default_nettype none
module lbs_front import lbs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [1:0]               opcode,
	input  wire logic [BONE_W-1:0]        bone,
	input  wire logic [IDX_W-1:0]         entry_index,
	input  wire logic signed [DATA_W-1:0] entry_value,
	input  wire logic signed [DATA_W-1:0] vertex_x,
	input  wire logic signed [DATA_W-1:0] vertex_y,
	input  wire logic signed [DATA_W-1:0] vertex_z,
	input  wire logic [WGT_W-1:0]         weight,
	input  wire logic                     last_of_vertex,
	input  wire logic                     back_busy,
	input  wire logic                     fifo_full,
	output logic                          fifo_push,
	output cmd_t                          fifo_wdata,
	output logic                          ram_we,
	output logic [TBL_AW-1:0]             ram_waddr,
	output logic [DATA_W-1:0]             ram_wdata
);
	logic [MAX_BONES-1:0] weighted_q;
	op_t                  op;
	logic                 accept;
	logic                 in_range;

	assign op       = op_t'(opcode);
	assign in_range = (int'(bone) < MAX_BONES);
	assign accept   = push && !full;

	// table writes wait until queued blends have read the table
	always_comb begin
		unique case (op)
			OP_MATRIX: full = back_busy;
			OP_BLEND:  full = fifo_full;
			default:   full = 1'b0;
		endcase
	end

	assign ram_we    = accept && (op == OP_MATRIX) && in_range
		&& (int'(entry_index) < MAT_ELEMS);
	assign ram_waddr = tbl_addr(bone, entry_index);
	assign ram_wdata = entry_value;

	assign fifo_push         = accept && (op == OP_BLEND);
	assign fifo_wdata.bone   = bone;
	assign fifo_wdata.x      = vertex_x;
	assign fifo_wdata.y      = vertex_y;
	assign fifo_wdata.z      = vertex_z;
	assign fifo_wdata.w      = weight;
	assign fifo_wdata.last   = last_of_vertex;
	assign fifo_wdata.active = in_range && weighted_q[bone];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= '0;
		end else if (accept && (op == OP_FLAG) && in_range) begin
			weighted_q[bone] <= entry_value[0];
		end
	end
endmodule
`default_nettype wire

[rtl/lbs_back.sv]
`default_nettype none
module lbs_back import lbs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fifo_empty,
	output logic                   fifo_pop,
	input  wire cmd_t              fifo_rdata,
	output logic [TBL_AW-1:0]      ram_raddr,
	input  wire logic [DATA_W-1:0] ram_rdata,
	output logic                   busy,
	output logic                   empty,
	input  wire logic              pop,
	output logic signed [31:0]     skinned_x,
	output logic signed [31:0]     skinned_y,
	output logic signed [31:0]     skinned_z,
	output logic                   saturated
);
	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MUL, S_ADD, S_WMUL, S_ACC, S_FIN
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [1:0]               row_q;
	logic [1:0]               col_q;
	logic signed [63:0]       prod_q;
	logic signed [49:0]       sum_q;
	logic signed [64:0]       wprod_q;
	logic signed [ACC_W-1:0]  acc_q [3];
	logic                     out_valid_q;
	logic signed [31:0]       out_x_q;
	logic signed [31:0]       out_y_q;
	logic signed [31:0]       out_z_q;
	logic                     out_sat_q;
	logic signed [DATA_W-1:0] vsel;
	logic signed [31:0]       cx;
	logic signed [31:0]       cy;
	logic signed [31:0]       cz;
	logic                     sx;
	logic                     sy;
	logic                     sz;

	function automatic logic signed [ACC_W-1:0] clamp48(input logic signed [50:0] v);
		if (!v[50] && (|v[49:47])) begin
			clamp48 = {1'b0, {(ACC_W-1){1'b1}}};
		end else if (v[50] && !(&v[49:47])) begin
			clamp48 = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			clamp48 = v[ACC_W-1:0];
		end
	endfunction

	function automatic logic [32:0] clamp32(input logic signed [ACC_W-1:0] v);
		if (!v[47] && (|v[46:31])) begin
			clamp32 = {1'b1, 32'h7fff_ffff};
		end else if (v[47] && !(&v[46:31])) begin
			clamp32 = {1'b1, 32'h8000_0000};
		end else begin
			clamp32 = {1'b0, v[31:0]};
		end
	endfunction

	assign {sx, cx} = clamp32(acc_q[0]);
	assign {sy, cy} = clamp32(acc_q[1]);
	assign {sz, cz} = clamp32(acc_q[2]);

	assign fifo_pop  = (state_q == S_IDLE) && !fifo_empty;
	assign ram_raddr = tbl_addr(cmd_q.bone, {row_q, col_q});
	assign busy      = (state_q != S_IDLE);
	assign empty     = !out_valid_q;
	assign skinned_x = out_x_q;
	assign skinned_y = out_y_q;
	assign skinned_z = out_z_q;
	assign saturated = out_sat_q;

	always_comb begin
		unique case (col_q)
			2'd0:    vsel = cmd_q.x;
			2'd1:    vsel = cmd_q.y;
			default: vsel = cmd_q.z;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= fifo_rdata;
				sum_q <= '0;
			end
			S_MUL: begin
				if (col_q == 2'd3) begin
					prod_q <= {{16{ram_rdata[31]}}, ram_rdata, 16'b0};
				end else begin
					prod_q <= $signed(ram_rdata) * vsel;
				end
			end
			S_ADD: sum_q <= sum_q + 50'(prod_q >>> 16);
			S_WMUL: wprod_q <= clamp48(51'(sum_q)) * $signed({1'b0, cmd_q.w});
			S_ACC: sum_q <= '0;
			default: ;
		endcase
		if (state_q == S_FIN && cmd_q.last && !out_valid_q) begin
			out_x_q   <= cx;
			out_y_q   <= cy;
			out_z_q   <= cz;
			out_sat_q <= sx | sy | sz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			acc_q[2]    <= '0;
		end else begin
			if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					if (!fifo_empty) begin
						state_q <= fifo_rdata.active ? S_RD : S_FIN;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (col_q == 2'd3) begin
						state_q <= S_WMUL;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_WMUL: state_q <= S_ACC;
				S_ACC: begin
					acc_q[row_q] <= clamp48(51'(acc_q[row_q]) + 51'(wprod_q >>> 15));
					col_q        <= '0;
					if (row_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (!cmd_q.last) begin
						state_q <= S_IDLE;
					end else if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						acc_q[0]    <= '0;
						acc_q[1]    <= '0;
						acc_q[2]    <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/blend_skinning_vertex.sv]
// Linear blend skinning, one vertex at a time. Items enter through a queue-style port:
// opcode 0 loads one Q16.16 element of a bone's 3x4 matrix, opcode 1 sets a bone's
// weighted flag, opcode 2 adds weight*M*[x y z 1] for that bone, and an opcode-2 beat
// with last_of_vertex set delivers the saturated position and clears the sums. Loads
// and flag writes bypass the queue; a matrix load is held off while blend work is queued
// or running, since it shares the table. Blends go through a 4-entry queue to a sequencer
// with one multiplier for matrix elements and one for weights, which reads the 12 matrix
// elements one at a time from the table RAM: a weighted contribution takes the beat, reads,
// multiplies and adds each element, weights and accumulates each row, then finishes; an
// unweighted one takes the beat and finishes.
// A result waits in an output register until popped; a last beat stalls there only if
// the previous result is still unread. No reads of unwritten matrix elements allowed.
`default_nettype none
`include "assert_macros.svh"
module blend_skinning_vertex import lbs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [1:0]               opcode,
	input  wire logic [BONE_W-1:0]        bone,
	input  wire logic [IDX_W-1:0]         entry_index,
	input  wire logic signed [DATA_W-1:0] entry_value,
	input  wire logic signed [DATA_W-1:0] vertex_x,
	input  wire logic signed [DATA_W-1:0] vertex_y,
	input  wire logic signed [DATA_W-1:0] vertex_z,
	input  wire logic [WGT_W-1:0]         weight,
	input  wire logic                     last_of_vertex,
	output logic                          empty,
	input  wire logic                     pop,
	output logic signed [31:0]            skinned_x,
	output logic signed [31:0]            skinned_y,
	output logic signed [31:0]            skinned_z,
	output logic                          saturated
);
	logic              fifo_push;
	logic              fifo_pop;
	logic              fifo_full;
	logic              fifo_empty;
	cmd_t              fifo_wdata;
	cmd_t              fifo_rdata;
	logic              ram_we;
	logic [TBL_AW-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [TBL_AW-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic              back_busy;
	logic              table_busy;

	assign table_busy = back_busy || !fifo_empty;

	lbs_front u_front (
		.clk, .arst_n, .push, .full, .opcode, .bone, .entry_index, .entry_value,
		.vertex_x, .vertex_y, .vertex_z, .weight, .last_of_vertex,
		.back_busy (table_busy),
		.fifo_full, .fifo_push, .fifo_wdata, .ram_we, .ram_waddr, .ram_wdata
	);

	lbs_fifo u_fifo (
		.clk, .arst_n,
		.push  (fifo_push),
		.wdata (fifo_wdata),
		.full  (fifo_full),
		.pop   (fifo_pop),
		.rdata (fifo_rdata),
		.empty (fifo_empty)
	);

	lbs_ram #(.WIDTH(DATA_W), .DEPTH(TBL_DEPTH)) u_table (
		.clk,
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lbs_back u_back (
		.clk, .arst_n, .fifo_empty, .fifo_pop, .fifo_rdata, .ram_raddr, .ram_rdata,
		.busy (back_busy),
		.empty, .pop, .skinned_x, .skinned_y, .skinned_z, .saturated
	);

	`LBS_ASSERT_IMP(a_no_overflow, clk, arst_n, fifo_push, !fifo_full, "queue overflow")
	`LBS_ASSERT_IMP(a_no_underflow, clk, arst_n, fifo_pop, !fifo_empty, "queue underflow")
	`LBS_ASSERT_IMP(a_table_quiet, clk, arst_n, ram_we, !table_busy, "table write during blend")
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none
module testbench;
	import lbs_pkg::*;

	localparam longint ACC_HI = 64'sd140737488355327;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam int N_ITEMS = 1550;
	localparam int LIMIT = 2000000;

	typedef struct {
		op_t op;
		logic [BONE_W-1:0] bone;
		logic [IDX_W-1:0] idx;
		logic signed [31:0] val;
		logic signed [31:0] x, y, z;
		logic [WGT_W-1:0] w;
		logic last;
	} item_t;

	typedef struct {
		logic signed [31:0] x, y, z;
		logic sat;
	} pos_t;

	class skin_board;
		logic [31:0] mtx [TBL_DEPTH];
		bit wtd [MAX_BONES];
		longint ax, ay, az;
		pos_t pend [$];
		int errors;
		int n_out;
		int n_sat;

		function new();
			foreach (mtx[i]) mtx[i] = '0;
			foreach (wtd[i]) wtd[i] = 0;
			ax = 0; ay = 0; az = 0;
			errors = 0; n_out = 0; n_sat = 0;
		endfunction

		function longint clamp48(longint v);
			if (v > ACC_HI) return ACC_HI;
			if (v < ACC_LO) return ACC_LO;
			return v;
		endfunction

		function longint row(int b, int r, longint x, longint y, longint z, longint w);
			longint s;
			logic signed [79:0] p;
			int base;
			base = b * MAT_ELEMS + r * 4;
			s = (longint'($signed(mtx[base])) * x) >>> 16;
			s += (longint'($signed(mtx[base + 1])) * y) >>> 16;
			s += (longint'($signed(mtx[base + 2])) * z) >>> 16;
			s += longint'($signed(mtx[base + 3]));
			s = clamp48(s);
			p = 80'(s) * $signed({16'b0, 64'(w)});
			return longint'(p >>> 15);
		endfunction

		function logic signed [31:0] out32(longint a, ref logic sat);
			if (a > 64'sd2147483647) begin
				sat = 1;
				return 32'sh7fffffff;
			end
			if (a < -64'sd2147483648) begin
				sat = 1;
				return 32'sh80000000;
			end
			return a[31:0];
		endfunction

		function void note(item_t it);
			pos_t r;
			longint x, y, z, w;
			case (it.op)
				OP_MATRIX: if (it.idx < MAT_ELEMS) mtx[it.bone * MAT_ELEMS + it.idx] = it.val;
				OP_FLAG: wtd[it.bone] = it.val[0];
				OP_BLEND: begin
					x = it.x; y = it.y; z = it.z; w = it.w;
					if (wtd[it.bone]) begin
						ax = clamp48(ax + row(it.bone, 0, x, y, z, w));
						ay = clamp48(ay + row(it.bone, 1, x, y, z, w));
						az = clamp48(az + row(it.bone, 2, x, y, z, w));
					end
					if (it.last) begin
						r.sat = 0;
						r.x = out32(ax, r.sat);
						r.y = out32(ay, r.sat);
						r.z = out32(az, r.sat);
						pend.push_back(r);
						ax = 0; ay = 0; az = 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check(pos_t got);
			pos_t e;
			if (pend.size() == 0) begin
				$error("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
				errors++;
				return;
			end
			e = pend.pop_front();
			n_out++;
			if (e.sat) n_sat++;
			if (got.x !== e.x) begin
				$error("skinned_x expected %0d actual %0d", e.x, got.x);
				errors++;
			end
			if (got.y !== e.y) begin
				$error("skinned_y expected %0d actual %0d", e.y, got.y);
				errors++;
			end
			if (got.z !== e.z) begin
				$error("skinned_z expected %0d actual %0d", e.z, got.z);
				errors++;
			end
			if (got.sat !== e.sat) begin
				$error("saturated expected %0b actual %0b", e.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] opcode = '0;
	logic [BONE_W-1:0] bone = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic signed [31:0] entry_value = '0;
	logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
	logic [WGT_W-1:0] weight = '0;
	logic last_of_vertex = 0;
	logic empty;
	logic pop = 0;
	logic signed [31:0] skinned_x, skinned_y, skinned_z;
	logic saturated;

	blend_skinning_vertex dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	skin_board board = new();
	item_t stim [$];
	bit loaded [TBL_DEPTH];
	bit gen_wtd [MAX_BONES];
	int hold = 0;
	bit calm = 0;
	int cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic signed [31:0] rval();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: return $urandom_range(0, 1) ? 32'sh00010000 : 32'shffff0000;
			default: return int'($urandom_range(0, 524287)) - 262144;
		endcase
	endfunction

	function automatic item_t noise();
		item_t it;
		it.op = op_t'($urandom_range(0, 3));
		it.bone = BONE_W'($urandom);
		it.idx = IDX_W'($urandom);
		it.val = $urandom;
		it.x = $urandom; it.y = $urandom; it.z = $urandom;
		it.w = WGT_W'($urandom);
		it.last = 1'($urandom);
		return it;
	endfunction

	function automatic bit ready(int b);
		for (int i = 0; i < MAT_ELEMS; i++)
			if (!loaded[b * MAT_ELEMS + i]) return 0;
		return 1;
	endfunction

	function automatic void add(item_t it);
		if (it.op == OP_BLEND && gen_wtd[it.bone] && !ready(it.bone))
			for (int i = 0; i < MAT_ELEMS; i++)
				if (!loaded[it.bone * MAT_ELEMS + i]) begin
					item_t m;
					m = noise();
					m.op = OP_MATRIX; m.bone = it.bone; m.idx = IDX_W'(i); m.val = rval();
					add(m);
				end
		if (it.op == OP_MATRIX && it.idx < MAT_ELEMS) loaded[it.bone * MAT_ELEMS + it.idx] = 1;
		if (it.op == OP_FLAG) gen_wtd[it.bone] = it.val[0];
		stim.push_back(it);
	endfunction

	function automatic item_t mk(op_t op, int b, logic last);
		item_t it;
		it = noise();
		it.op = op; it.bone = BONE_W'(b); it.last = last;
		if (op == OP_BLEND) begin
			it.x = rval(); it.y = rval(); it.z = rval();
			case ($urandom_range(0, 5))
				0: it.w = 16'd32768;
				1: it.w = WGT_W'($urandom);
				default: it.w = WGT_W'($urandom_range(0, 32768));
			endcase
		end
		return it;
	endfunction

	function automatic void build();
		item_t it;
		int n;
		// directed: extremes, every opcode, ignored cases
		for (int i = 0; i < MAT_ELEMS; i++) begin
			it = mk(OP_MATRIX, 63, 0);
			it.idx = IDX_W'(i);
			it.val = (i % 5 == 0) ? 32'sh00010000 : (i == 3 ? 32'sh7fffffff : 32'sh80000000);
			add(it);
		end
		it = mk(OP_MATRIX, 63, 1); it.idx = 4'd13; add(it);
		it = mk(OP_FLAG, 63, 1); it.val = 1; add(it);
		it = mk(OP_BLEND, 63, 0); it.x = 32'sh7fffffff; it.y = 32'sh80000000;
		it.z = 32'sh7fffffff; it.w = 16'hffff; add(it);
		it = mk(OP_BLEND, 63, 1); it.w = '0; add(it);
		it = mk(OP_BLEND, 0, 1); add(it);
		it = mk(OP_NONE, 63, 1); add(it);
		it = mk(OP_BLEND, 63, 1); it.x = 32'sh80000000; it.w = 16'd32768; add(it);
		it = mk(OP_FLAG, 63, 0); it.val = 0; add(it);
		it = mk(OP_BLEND, 63, 1); add(it);
		while (stim.size() < N_ITEMS) begin
			n = $urandom_range(0, 99);
			if (n < 6) begin
				it = noise();
				if (it.op == OP_BLEND) it = mk(OP_BLEND, it.bone, it.last);
				add(it);
			end else if (n < 14) begin
				it = mk(OP_FLAG, $urandom_range(0, 63), 0); it.val = $urandom_range(0, 3); add(it);
			end else if (n < 22) begin
				it = mk(OP_MATRIX, $urandom_range(0, 63), 0); it.idx = IDX_W'($urandom);
				it.val = rval(); add(it);
			end else begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++) begin
					int b;
					b = $urandom_range(0, 63);
					if ($urandom_range(0, 9) < 7 && !gen_wtd[b]) begin
						it = mk(OP_FLAG, b, 0); it.val = 1; add(it);
					end
					add(mk(OP_BLEND, b, k == n - 1));
				end
			end
		end
	endfunction

	task automatic send_all();
		for (int i = 0; i < stim.size(); i++) begin
			if (i == 300) hold = 400;
			if (i == 700) begin
				@(negedge clk);
				push = 0;
				while (board.pend.size() != 0) @(posedge clk);
			end
			calm = (i >= 1000 && i < 1200);
			@(negedge clk);
			while (!calm && $urandom_range(0, 99) < 19) begin
				push = 0;
				@(negedge clk);
			end
			push = 1;
			opcode = stim[i].op; bone = stim[i].bone; entry_index = stim[i].idx;
			entry_value = stim[i].val;
			vertex_x = stim[i].x; vertex_y = stim[i].y; vertex_z = stim[i].z;
			weight = stim[i].w; last_of_vertex = stim[i].last;
			@(posedge clk);
			while (full) @(posedge clk);
			board.note(stim[i]);
		end
		@(negedge clk);
		push = 0;
	endtask

	initial begin
		pos_t got;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				pop = 0;
			end else
				pop = calm || $urandom_range(0, 99) >= 19;
			@(posedge clk);
			if (pop && !empty) begin
				got.x = skinned_x; got.y = skinned_y; got.z = skinned_z; got.sat = saturated;
				board.check(got);
			end
		end
	end

	initial begin
		build();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_all();
		while (board.pend.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d items; checked %0d skinned positions, %0d saturated.",
			stim.size(), board.n_out, board.n_sat);
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/lbs_pkg.sv
rtl/lbs_ram.sv
rtl/lbs_fifo.sv
rtl/lbs_front.sv
rtl/lbs_back.sv
rtl/blend_skinning_vertex.sv
tb/sv/testbench.sv
